// File: hw/rtl/ssfs_pkg.sv
`default_nettype none

package ssfs_pkg;

    // Capture counter width; sit time wraps modulo 2**COUNTER_BITS
    localparam int COUNTER_BITS = 16;

    // Servo geometry
    localparam int ANGLE_W = 9;
    localparam int PULSE_W = 11;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 9'd180;
    localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Item kind codes
    localparam logic [1:0] FUNC_CAPTURE     = 2'd0;
    localparam logic [1:0] FUNC_OVERCAPTURE = 2'd1;
    localparam logic [1:0] FUNC_TICK        = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_OCCUPIED_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_FLUSH_DELAY        = 3'd1;
    localparam logic [2:0] REG_INTER_SWEEP        = 3'd2;
    localparam logic [2:0] REG_STEP_DEGREES       = 3'd3;
    localparam logic [2:0] REG_SWEEP_COUNT        = 3'd4;

    typedef struct packed {
        logic [1:0]              func;
        logic [COUNTER_BITS-1:0] capture_time;
        logic                    pin_level;
    } ssfs_item_t;

    typedef struct packed {
        logic               seated;
        logic               red_led;
        logic               blue_led;
        logic [PULSE_W-1:0] servo_pulse_us;
        logic               sweep_active;
    } ssfs_result_t;

    typedef struct packed {
        logic [COUNTER_BITS-1:0] sit_threshold;
        logic [15:0]             flush_delay_ticks;
        logic [15:0]             inter_sweep_ticks;
        logic [5:0]              step_degrees;
        logic [1:0]              sweep_count;
    } ssfs_cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/ssfs_cfg.sv
`default_nettype none

module ssfs_cfg
    import ssfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output ssfs_cfg_t                  cfg
);

    logic [15:0] threshold_reg;
    logic [15:0] flush_delay_reg;
    logic [15:0] inter_sweep_reg;
    logic [5:0]  step_reg;
    logic [1:0]  sweep_count_reg;
    logic [2:0]  reg_index;
    logic        wr_en;

    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= 16'd1000;
            flush_delay_reg <= 16'd50;
            inter_sweep_reg <= 16'd100;
            step_reg        <= 6'd8;
            sweep_count_reg <= 2'd2;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_OCCUPIED_THRESHOLD: threshold_reg   <= pwdata[15:0];
                REG_FLUSH_DELAY:        flush_delay_reg <= pwdata[15:0];
                REG_INTER_SWEEP:        inter_sweep_reg <= pwdata[15:0];
                REG_STEP_DEGREES:       step_reg        <= pwdata[5:0];
                REG_SWEEP_COUNT:        sweep_count_reg <= pwdata[1:0];
                default:                ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_index)
            REG_OCCUPIED_THRESHOLD: prdata = {16'd0, threshold_reg};
            REG_FLUSH_DELAY:        prdata = {16'd0, flush_delay_reg};
            REG_INTER_SWEEP:        prdata = {16'd0, inter_sweep_reg};
            REG_STEP_DEGREES:       prdata = {26'd0, step_reg};
            REG_SWEEP_COUNT:        prdata = {30'd0, sweep_count_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.sit_threshold     = threshold_reg;
    assign cfg.flush_delay_ticks = flush_delay_reg;
    assign cfg.inter_sweep_ticks = inter_sweep_reg;
    assign cfg.step_degrees      = step_reg;
    assign cfg.sweep_count       = sweep_count_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ssfs_core.sv
`default_nettype none

module ssfs_core
    import ssfs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire ssfs_item_t   item,
    input  wire ssfs_cfg_t    cfg,
    output ssfs_result_t      result_next
);

    // 1000/180 = 50/9; floor(n/9) == (n*7282)>>16 for n <= 9000
    localparam int PROD_W = 27;
    localparam logic [PROD_W-1:0] PULSE_SCALE = 27'd364100;

    logic                    seated_reg,     seated_next;
    logic [COUNTER_BITS-1:0] sit_start_reg,  sit_start_next;
    logic [ANGLE_W-1:0]      angle_reg,      angle_next;
    logic                    moving_down_reg, moving_down_next;
    logic                    sweep_en_reg,   sweep_en_next;
    logic                    reached_top_reg, reached_top_next;
    logic [15:0]             delay_reg,      delay_next;
    logic [1:0]              sweeps_left_reg, sweeps_left_next;
    logic                    red_reg,        red_next;
    logic                    blue_reg,       blue_next;

    logic [COUNTER_BITS-1:0] elapsed;
    logic [ANGLE_W-1:0]      step_ext;
    logic [ANGLE_W-1:0]      angle_up;
    logic [PROD_W-1:0]       pulse_prod;

    assign elapsed  = item.capture_time - sit_start_reg;
    assign step_ext = ANGLE_W'(cfg.step_degrees);

    // Next state for one transaction
    always_comb
    begin
        seated_next      = seated_reg;
        sit_start_next   = sit_start_reg;
        angle_next       = angle_reg;
        moving_down_next = moving_down_reg;
        sweep_en_next    = sweep_en_reg;
        reached_top_next = reached_top_reg;
        delay_next       = delay_reg;
        sweeps_left_next = sweeps_left_reg;
        red_next         = red_reg;
        blue_next        = blue_reg;
        angle_up         = angle_reg + step_ext;

        unique case (item.func)
            FUNC_CAPTURE:
            begin
                if (!item.pin_level)
                begin
                    // sit down: new session, cancel any pending flush
                    if (!seated_reg)
                    begin
                        seated_next      = 1'b1;
                        sit_start_next   = item.capture_time;
                        red_next         = 1'b0;
                        blue_next        = 1'b0;
                        sweep_en_next    = 1'b0;
                        reached_top_next = 1'b0;
                        delay_next       = '0;
                        sweeps_left_next = '0;
                    end
                end
                else if (seated_reg)
                begin
                    // stand up: judge sit time
                    seated_next = 1'b0;
                    red_next    = 1'b1;
                    if (elapsed >= cfg.sit_threshold)
                    begin
                        blue_next        = 1'b1;
                        angle_next       = '0;
                        moving_down_next = 1'b0;
                        reached_top_next = 1'b0;
                        sweep_en_next    = 1'b0;
                        delay_next       = cfg.flush_delay_ticks;
                        sweeps_left_next = cfg.sweep_count;
                    end
                    else
                    begin
                        blue_next        = 1'b0;
                        sweep_en_next    = 1'b0;
                        reached_top_next = 1'b0;
                        delay_next       = '0;
                        sweeps_left_next = '0;
                    end
                end
            end

            FUNC_OVERCAPTURE:
            begin
                seated_next      = 1'b0;
                blue_next        = 1'b0;
                red_next         = 1'b1;
                sweep_en_next    = 1'b0;
                reached_top_next = 1'b0;
                delay_next       = '0;
                sweeps_left_next = '0;
            end

            FUNC_TICK:
            begin
                // delay countdown, possibly starting a sweep
                if (!sweep_en_reg && (delay_reg != '0))
                begin
                    delay_next = delay_reg - 16'd1;
                    if ((delay_next == '0) && (sweeps_left_reg != '0))
                    begin
                        angle_next       = '0;
                        moving_down_next = 1'b0;
                        reached_top_next = 1'b0;
                        sweep_en_next    = 1'b1;
                        sweeps_left_next = sweeps_left_reg - 2'd1;
                    end
                end
                angle_up = angle_next + step_ext;

                // one servo step
                if (sweep_en_next)
                begin
                    if (!moving_down_next)
                    begin
                        if (angle_up >= ANGLE_MAX)
                        begin
                            angle_next       = ANGLE_MAX;
                            moving_down_next = 1'b1;
                            reached_top_next = 1'b1;
                        end
                        else
                        begin
                            angle_next = angle_up;
                        end
                    end
                    else if (angle_next <= step_ext)
                    begin
                        angle_next = '0;
                        if (reached_top_next)
                        begin
                            sweep_en_next = 1'b0;
                            if (sweeps_left_next != '0)
                            begin
                                moving_down_next = 1'b0;
                                reached_top_next = 1'b0;
                                delay_next       = cfg.inter_sweep_ticks;
                            end
                        end
                        else
                        begin
                            moving_down_next = 1'b0;
                        end
                    end
                    else
                    begin
                        angle_next = angle_next - step_ext;
                    end
                end
            end

            default: ;
        endcase
    end

    // Pulse width tracks the angle, which always stays within 0..180
    assign pulse_prod = PROD_W'(angle_next) * PULSE_SCALE;

    assign result_next.seated         = seated_next;
    assign result_next.red_led        = red_next;
    assign result_next.blue_led       = blue_next;
    assign result_next.servo_pulse_us = PULSE_MIN + pulse_prod[PROD_W-1:16];
    assign result_next.sweep_active   = sweep_en_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seated_reg      <= 1'b0;
            sit_start_reg   <= '0;
            angle_reg       <= '0;
            moving_down_reg <= 1'b0;
            sweep_en_reg    <= 1'b0;
            reached_top_reg <= 1'b0;
            delay_reg       <= '0;
            sweeps_left_reg <= '0;
            red_reg         <= 1'b0;
            blue_reg        <= 1'b0;
        end
        else if (step)
        begin
            seated_reg      <= seated_next;
            sit_start_reg   <= sit_start_next;
            angle_reg       <= angle_next;
            moving_down_reg <= moving_down_next;
            sweep_en_reg    <= sweep_en_next;
            reached_top_reg <= reached_top_next;
            delay_reg       <= delay_next;
            sweeps_left_reg <= sweeps_left_next;
            red_reg         <= red_next;
            blue_reg        <= blue_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/seat_sensed_flush_servo_sequencer.sv
// The item is held in the input register; the state update and pulse multiply are
// combinational, and their result moves into the result register when that is free or read.
// Throughput: one item per cycle while results are taken.
// A new item is taken while a result waits, as long as the input register is free.
// Reset (rst_n, async, active low): not seated, LEDs off, no sweep pending, angle 0,
// pulse 1000 us, configuration registers at their default values.
`default_nettype none

module seat_sensed_flush_servo_sequencer
    import ssfs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire ssfs_item_t            item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output ssfs_result_t               result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    ssfs_cfg_t    cfg;
    ssfs_item_t   item_reg;
    logic         item_valid_reg;
    ssfs_result_t result_reg;
    logic         result_valid_reg;
    ssfs_result_t result_next;
    logic         advance;

    ssfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Move the held item into the result slot when it is free or draining
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    ssfs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// File: bench/tb_seat_sensed_flush_servo_sequencer.sv
module tb_seat_sensed_flush_servo_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import ssfs_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES = 120;
    localparam int PULSE_SPAN = 1000;

    // One row of the directed table
    typedef struct {
        ssfs_item_t   it;
        bit           typed;
        ssfs_result_t exp;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_ready;
    ssfs_item_t   item = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    ssfs_result_t result;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic         pready;

    // Typed expectation travels with the item it belongs to
    bit           row_typed = 1'b0;
    ssfs_result_t row_exp = '0;

    seat_sensed_flush_servo_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Register shadow and seat/servo state mirror
    ssfs_cfg_t   cfg_shadow = '{16'd1000, 16'd50, 16'd100, 6'd8, 2'd2};
    logic        m_seated = 1'b0;
    logic [15:0] m_sit = '0;
    int          m_angle = 0;
    logic        m_down = 1'b0;
    logic        m_sweeping = 1'b0;
    logic        m_top = 1'b0;
    logic [15:0] m_delay = '0;
    logic [1:0]  m_left = '0;
    logic        m_red = 1'b0;
    logic        m_blue = 1'b0;
    logic [10:0] m_pulse = PULSE_MIN;

    ssfs_result_t pending_indicators[$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int sweep_results = 0;
    int full_travel = 0;
    int hold_reqs = 0;

    // Stimulus generator view of the seat
    logic        gen_seated = 1'b0;
    logic [15:0] gen_sit_t = '0;

    function automatic logic [10:0] pulse_of(int a);
        if (a < 0) a = 0;
        if (a > int'(ANGLE_MAX)) a = int'(ANGLE_MAX);
        return 11'(a * PULSE_SPAN / int'(ANGLE_MAX) + int'(PULSE_MIN));
    endfunction

    function automatic void drop_flush();
        m_sweeping = 1'b0;
        m_top = 1'b0;
        m_delay = '0;
        m_left = '0;
    endfunction

    // Applies one item to the mirror and returns the indicators it leaves
    function automatic ssfs_result_t step_seat_model(ssfs_item_t it);
        logic [15:0] elapsed;
        ssfs_result_t r;
        case (it.func)
            FUNC_CAPTURE:
            begin
                if (!it.pin_level)
                begin
                    if (!m_seated)
                    begin
                        m_seated = 1'b1;
                        m_sit = it.capture_time;
                        m_red = 1'b0;
                        m_blue = 1'b0;
                        drop_flush();
                    end
                end
                else if (m_seated)
                begin
                    elapsed = it.capture_time - m_sit;
                    m_seated = 1'b0;
                    m_red = 1'b1;
                    if (elapsed >= cfg_shadow.sit_threshold)
                    begin
                        m_blue = 1'b1;
                        m_angle = 0;
                        m_down = 1'b0;
                        m_top = 1'b0;
                        m_sweeping = 1'b0;
                        m_delay = cfg_shadow.flush_delay_ticks;
                        m_left = cfg_shadow.sweep_count;
                        m_pulse = pulse_of(m_angle);
                    end
                    else
                    begin
                        m_blue = 1'b0;
                        drop_flush();
                    end
                end
            end
            FUNC_OVERCAPTURE:
            begin
                m_seated = 1'b0;
                m_blue = 1'b0;
                m_red = 1'b1;
                drop_flush();
            end
            FUNC_TICK:
            begin
                // pending delay, possibly launching the next sweep
                if (!m_sweeping && m_delay != 0)
                begin
                    m_delay = m_delay - 16'd1;
                    if (m_delay == 0 && m_left != 0)
                    begin
                        m_angle = 0;
                        m_down = 1'b0;
                        m_top = 1'b0;
                        m_sweeping = 1'b1;
                        m_left = m_left - 2'd1;
                        m_pulse = pulse_of(m_angle);
                    end
                end
                // servo motion
                if (m_sweeping)
                begin
                    if (!m_down)
                    begin
                        m_angle = m_angle + int'(cfg_shadow.step_degrees);
                        if (m_angle >= int'(ANGLE_MAX))
                        begin
                            m_angle = int'(ANGLE_MAX);
                            m_down = 1'b1;
                            m_top = 1'b1;
                        end
                    end
                    else
                    begin
                        m_angle = m_angle - int'(cfg_shadow.step_degrees);
                        if (m_angle <= 0)
                        begin
                            m_angle = 0;
                            if (m_top)
                            begin
                                m_sweeping = 1'b0;
                                if (m_left != 0)
                                begin
                                    m_down = 1'b0;
                                    m_top = 1'b0;
                                    m_delay = cfg_shadow.inter_sweep_ticks;
                                end
                            end
                            else
                            begin
                                m_down = 1'b0;
                            end
                        end
                    end
                    m_pulse = pulse_of(m_angle);
                end
            end
            default: ;
        endcase
        r.seated = m_seated;
        r.red_led = m_red;
        r.blue_led = m_blue;
        r.servo_pulse_us = m_pulse;
        r.sweep_active = m_sweeping;
        return r;
    endfunction

    // Result check first, then the expectation of a newly accepted item
    always @(posedge clk)
    begin : scoreboard
        ssfs_result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (result.sweep_active) sweep_results++;
                if (result.servo_pulse_us == 11'd2000) full_travel++;
                if (pending_indicators.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: %p", $realtime, result);
                end
                else
                begin
                    want = pending_indicators.pop_front();
                    if (result.seated !== want.seated ||
                        result.red_led !== want.red_led ||
                        result.blue_led !== want.blue_led ||
                        result.servo_pulse_us !== want.servo_pulse_us ||
                        result.sweep_active !== want.sweep_active)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch exp seated=%0d red=%0d blue=%0d pulse=%0d act=%0d",
                                     $realtime, want.seated, want.red_led, want.blue_led,
                                     want.servo_pulse_us, want.sweep_active);
                            $display("    got seated=%0d red=%0d blue=%0d pulse=%0d act=%0d",
                                     result.seated, result.red_led, result.blue_led,
                                     result.servo_pulse_us, result.sweep_active);
                        end
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                want = step_seat_model(item);
                pending_indicators.push_back(row_typed ? row_exp : want);
            end
        end
    end

    // Result side: own stall pattern plus long hold-offs on request
    initial
    begin : receiver
        int rc;
        int hold_left;
        int hold_seen;
        rc = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            rc++;
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case ((rc / 89) % 4)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom_range(0, 1));
                    2: result_ready <= (rc % 4 == 0);
                    default: result_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    task automatic offer(ssfs_item_t it, bit typed, ssfs_result_t exp);
        item_valid <= 1'b1;
        item <= it;
        row_typed <= typed;
        row_exp <= exp;
        do @(posedge clk); while (!item_ready);
        items_sent++;
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_indicators.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OCCUPIED_THRESHOLD: cfg_shadow.sit_threshold = val;
            REG_FLUSH_DELAY:        cfg_shadow.flush_delay_ticks = val;
            REG_INTER_SWEEP:        cfg_shadow.inter_sweep_ticks = val;
            REG_STEP_DEGREES:       cfg_shadow.step_degrees = val[5:0];
            REG_SWEEP_COUNT:        cfg_shadow.sweep_count = val[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Mostly ticks to run the sweeps, plus sit/stand pairs around the threshold and other kinds
    task automatic pick_item(output ssfs_item_t it, output bit counts);
        int r;
        logic stand;
        logic [15:0] span;
        r = $urandom_range(0, 99);
        it.func = FUNC_TICK;
        it.capture_time = 16'($urandom);
        it.pin_level = 1'($urandom);
        counts = 1'b1;
        if (r < 58)
        begin
            it.func = FUNC_TICK;
        end
        else if (r < 86)
        begin
            it.func = FUNC_CAPTURE;
            stand = gen_seated;
            if ($urandom_range(0, 9) == 0)
            begin
                // repeated level, ignored by the block
                stand = !gen_seated;
                counts = 1'b0;
            end
            it.pin_level = stand;
            if (counts && !stand)
            begin
                gen_sit_t = it.capture_time;
                gen_seated = 1'b1;
            end
            else if (counts)
            begin
                case ($urandom_range(0, 3))
                    0: span = cfg_shadow.sit_threshold + 16'($urandom_range(0, 40));
                    1: span = cfg_shadow.sit_threshold - 16'd1;
                    2: span = cfg_shadow.sit_threshold;
                    default: span = 16'($urandom);
                endcase
                it.capture_time = gen_sit_t + span;
                gen_seated = 1'b0;
            end
        end
        else if (r < 91)
        begin
            it.func = FUNC_OVERCAPTURE;
            gen_seated = 1'b0;
        end
        else if (r < 94)
        begin
            it.func = FUNC_UNUSED;
            counts = 1'b0;
        end
        else
        begin
            // noise: any kind, any fields
            it.func = 2'($urandom);
            if (it.func == FUNC_OVERCAPTURE) gen_seated = 1'b0;
            if (it.func == FUNC_CAPTURE)
            begin
                if (!it.pin_level && !gen_seated) gen_sit_t = it.capture_time;
                gen_seated = !it.pin_level;
            end
        end
    endtask

    function automatic dir_row_t drow(logic [1:0] f, logic [15:0] t, logic p, bit typed,
                                      logic [14:0] e);
        dir_row_t row;
        row.it.func = f;
        row.it.capture_time = t;
        row.it.pin_level = p;
        row.typed = typed;
        row.exp = e;
        return row;
    endfunction

    // Per-phase register settings; the last two phases are drawn at random
    int ph_thr[8]   = '{20, 0, 65535, 100, 50, 30, 10, 200};
    int ph_delay[8] = '{3, 1, 65535, 2, 0, 4, 2, 5};
    int ph_inter[8] = '{2, 0, 65535, 5, 3, 1, 3, 8};
    int ph_step[8]  = '{30, 60, 1, 7, 13, 0, 63, 23};
    int ph_count[8] = '{3, 2, 1, 0, 3, 2, 3, 1};

    initial
    begin : sender
        dir_row_t rows[$];
        ssfs_item_t it;
        bit counts;
        bit held;
        int n;
        int burst;
        logic [15:0] thr, dly, gap_ticks, stp, cnt;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings (threshold 1000, delay 50)
        rows.push_back(drow(FUNC_TICK,        16'h0000, 1'b0, 1, {3'b000, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_UNUSED,      16'hFFFF, 1'b1, 1, {3'b000, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'hFFFF, 1'b1, 1, {3'b000, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_OVERCAPTURE, 16'h0000, 1'b0, 1, {3'b010, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'hFFF0, 1'b0, 1, {3'b100, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'h0000, 1'b0, 1, {3'b100, 11'd1000, 1'b0}));
        // short sit across the counter wrap
        rows.push_back(drow(FUNC_CAPTURE,     16'h0010, 1'b1, 1, {3'b010, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'hFC18, 1'b0, 1, {3'b100, 11'd1000, 1'b0}));
        // exactly the threshold, across the wrap
        rows.push_back(drow(FUNC_CAPTURE,     16'h0000, 1'b1, 1, {3'b011, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_TICK,        16'h0000, 1'b0, 0, '0));
        rows.push_back(drow(FUNC_OVERCAPTURE, 16'hFFFF, 1'b1, 1, {3'b010, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'h0000, 1'b0, 1, {3'b100, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'd999,  1'b1, 1, {3'b010, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'h1234, 1'b0, 1, {3'b100, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'h161C, 1'b1, 1, {3'b011, 11'd1000, 1'b0}));
        repeat (5) rows.push_back(drow(FUNC_TICK, 16'h5555, 1'b1, 0, '0));
        rows.push_back(drow(FUNC_UNUSED,      16'h0000, 1'b0, 0, '0));
        // new sit cancels the pending flush
        rows.push_back(drow(FUNC_CAPTURE,     16'hFFFF, 1'b0, 1, {3'b100, 11'd1000, 1'b0}));
        rows.push_back(drow(FUNC_CAPTURE,     16'hFFFF, 1'b1, 1, {3'b010, 11'd1000, 1'b0}));
        foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].exp);

        // Random phases, each at its own register setting
        held = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_results();
            if (ph < 8)
            begin
                thr = 16'(ph_thr[ph]);
                dly = 16'(ph_delay[ph]);
                gap_ticks = 16'(ph_inter[ph]);
                stp = 16'(ph_step[ph]);
                cnt = 16'(ph_count[ph]);
            end
            else
            begin
                thr = 16'($urandom_range(0, 300));
                dly = 16'($urandom_range(0, 6));
                gap_ticks = 16'($urandom_range(0, 6));
                stp = 16'($urandom_range(0, 63));
                cnt = 16'($urandom_range(0, 3));
            end
            write_reg(REG_OCCUPIED_THRESHOLD, thr);
            write_reg(REG_FLUSH_DELAY, dly);
            write_reg(REG_INTER_SWEEP, gap_ticks);
            write_reg(REG_STEP_DEGREES, stp);
            write_reg(REG_SWEEP_COUNT, cnt);

            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst; b++)
                begin
                    pick_item(it, counts);
                    offer(it, 1'b0, '0);
                    if (counts) n++;
                    // long receiver hold-off while items keep coming
                    if (ph == 0 && !held && n >= 40)
                    begin
                        hold_reqs++;
                        held = 1'b1;
                    end
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    item_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        $display("Covered %0d item transactions over %0d register settings plus the reset one.",
                 items_sent, PHASES);
        $display("Checked %0d results: %0d during a sweep, %0d at full travel.",
                 results_seen, sweep_results, full_travel);
        if (mismatches == 0 && pending_indicators.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
